>>> rtl/rmqi_pkg.sv
`default_nettype none

package rmqi_pkg;

  // Fixed field widths
  localparam int REV_MESH_W = 6;
  localparam int COLOR_W    = 9;
  localparam int VTX_W      = 16;
  localparam int VCNT_W     = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [REV_MESH_W-1:0] REV_MESH_RST = REV_MESH_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REV_MESH      = 2'd0,
    CFG_CLOSED_REV    = 2'd1,
    CFG_COLOR_INSIDE  = 2'd2,
    CFG_COLOR_OUTSIDE = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } seq_state_t;

  localparam logic [VCNT_W-1:0] VCNT_TRI  = VCNT_W'(3);
  localparam logic [VCNT_W-1:0] VCNT_QUAD = VCNT_W'(4);

  // Sequencer to face unit
  typedef struct packed {
    logic a_full;
    logic b_full;
    logic reversed;
  } face_ctl_t;

  // Face unit result
  typedef struct packed {
    logic [VCNT_W-1:0] vertex_count;
    logic [VTX_W-1:0]  vertex_a;
    logic [VTX_W-1:0]  vertex_b;
    logic [VTX_W-1:0]  vertex_c;
    logic [VTX_W-1:0]  vertex_d;
    logic              overflow;
  } face_t;

endpackage

`default_nettype wire

>>> rtl/revolved_mesh_quad_indexer.sv
// An accepted ring with faces moves the sequencer to ST_EMIT; each emitted face is
// registered at the output. Throughput: one face per cycle unless the output stalls,
// set by the single face builder stepped by the sequencer; a ring emits up to 2 * steps
// faces. A faceless ring stays in ST_IDLE. in_ready is low while faces are produced.
// Reset (rst_n low at a clock edge) clears ring state and loads the register defaults.
`default_nettype none

module revolved_mesh_quad_indexer #(
  parameter int MAX_REV_MESH = 32,
  parameter int INDEX_BITS   = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_ring_full,
  input  wire logic                                   in_starts_mesh,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [rmqi_pkg::VCNT_W-1:0]                 out_vertex_count,
  output logic [rmqi_pkg::VTX_W-1:0]                  out_vertex_a,
  output logic [rmqi_pkg::VTX_W-1:0]                  out_vertex_b,
  output logic [rmqi_pkg::VTX_W-1:0]                  out_vertex_c,
  output logic [rmqi_pkg::VTX_W-1:0]                  out_vertex_d,
  output logic [7:0]                                  out_face_color,
  output logic                                        out_index_overflow,
  output logic                                        out_last_face,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [rmqi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [rmqi_pkg::COLOR_W-1:0]           cfg_data
);

  localparam int IW  = INDEX_BITS + 1;
  localparam int RW  = $clog2(MAX_REV_MESH);
  localparam int SW  = $clog2(MAX_REV_MESH + 1);
  localparam int PW  = $clog2(MAX_REV_MESH + 2);
  localparam int RMW = rmqi_pkg::REV_MESH_W;
  localparam int CW  = rmqi_pkg::COLOR_W;

  logic [RMW-1:0] rev_mesh_r;
  logic           closed_r;
  logic [CW-1:0]  color_in_r, color_out_r;

  logic [SW-1:0]  steps;
  logic [PW-1:0]  pts_out;
  logic           en_in, en_out;

  logic                 emit, last, outside, out_space;
  rmqi_pkg::face_ctl_t  ctl;
  logic [RW-1:0]        pos;
  logic [IW-1:0]        a_start, b_start;
  rmqi_pkg::face_t      face;

  logic                 out_valid_r;
  rmqi_pkg::face_t      out_face_r;
  logic [7:0]           out_color_r;
  logic                 out_last_r;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_mesh_r  <= rmqi_pkg::REV_MESH_RST;
      closed_r    <= 1'b0;
      color_in_r  <= '1;
      color_out_r <= '1;
    end else if (cfg_valid) begin
      case (rmqi_pkg::cfg_reg_e'(cfg_index))
        rmqi_pkg::CFG_REV_MESH:      rev_mesh_r  <= cfg_data[RMW-1:0];
        rmqi_pkg::CFG_CLOSED_REV:    closed_r    <= cfg_data[0];
        rmqi_pkg::CFG_COLOR_INSIDE:  color_in_r  <= cfg_data;
        rmqi_pkg::CFG_COLOR_OUTSIDE: color_out_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // rev_mesh clamped to 1..MAX_REV_MESH
  always_comb begin
    if (rev_mesh_r == '0) begin
      steps = SW'(1);
    end else if (rev_mesh_r > RMW'(MAX_REV_MESH)) begin
      steps = SW'(MAX_REV_MESH);
    end else begin
      steps = SW'(rev_mesh_r);
    end
  end

  assign pts_out = closed_r ? PW'(steps) : PW'(steps) + PW'(1);
  assign en_in   = !color_in_r[CW-1];
  assign en_out  = !color_out_r[CW-1];

  assign out_space = !out_valid_r || out_ready;

  rmqi_seq #(
    .MAX_REV_MESH (MAX_REV_MESH),
    .INDEX_BITS   (INDEX_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ring_full   (in_ring_full),
    .starts_mesh (in_starts_mesh),
    .steps       (steps),
    .pts_out     (pts_out),
    .en_in       (en_in),
    .en_out      (en_out),
    .out_space   (out_space),
    .emit        (emit),
    .last        (last),
    .outside     (outside),
    .ctl         (ctl),
    .pos         (pos),
    .a_start     (a_start),
    .b_start     (b_start)
  );

  rmqi_face #(
    .MAX_REV_MESH (MAX_REV_MESH),
    .INDEX_BITS   (INDEX_BITS)
  ) u_face (
    .a_start (a_start),
    .b_start (b_start),
    .pos     (pos),
    .pts_out (pts_out),
    .ctl     (ctl),
    .face    (face)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_face_r  <= face;
      out_color_r <= outside ? color_out_r[7:0] : color_in_r[7:0];
      out_last_r  <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_vertex_count   = out_face_r.vertex_count;
  assign out_vertex_a       = out_face_r.vertex_a;
  assign out_vertex_b       = out_face_r.vertex_b;
  assign out_vertex_c       = out_face_r.vertex_c;
  assign out_vertex_d       = out_face_r.vertex_d;
  assign out_face_color     = out_color_r;
  assign out_index_overflow = out_face_r.overflow;
  assign out_last_face      = out_last_r;

endmodule

`default_nettype wire

>>> rtl/rmqi_face.sv
`default_nettype none

// Builds one face from the two ring starts and the angular position.
module rmqi_face #(
  parameter int MAX_REV_MESH = 32,
  parameter int INDEX_BITS   = 16
) (
  input  wire logic [INDEX_BITS:0]                  a_start,
  input  wire logic [INDEX_BITS:0]                  b_start,
  input  wire logic [$clog2(MAX_REV_MESH)-1:0]      pos,
  input  wire logic [$clog2(MAX_REV_MESH+2)-1:0]    pts_out,
  input  wire rmqi_pkg::face_ctl_t                  ctl,
  output rmqi_pkg::face_t                           face
);

  localparam int IW    = INDEX_BITS + 1;
  localparam int PW    = $clog2(MAX_REV_MESH + 2);
  localparam int VW    = rmqi_pkg::VTX_W;
  localparam int EXT_W = (INDEX_BITS > VW) ? INDEX_BITS : VW;

  logic [PW-1:0] nx_inc;
  logic [PW-1:0] nx;
  logic [IW-1:0] a_r, a_n, b_r, b_n;

  assign nx_inc = PW'(pos) + PW'(1);
  assign nx     = (nx_inc >= pts_out) ? '0 : nx_inc;
  assign a_r    = a_start + IW'(pos);
  assign a_n    = a_start + IW'(nx);
  assign b_r    = b_start + IW'(pos);
  assign b_n    = b_start + IW'(nx);

  always_comb begin
    logic [IW-1:0]         q [4];
    logic [IW-1:0]         v [4];
    logic [INDEX_BITS-1:0] s [4];
    logic [EXT_W-1:0]      e [4];
    logic                  quad;
    logic                  ovf;

    quad = ctl.a_full && ctl.b_full;
    case ({ctl.a_full, ctl.b_full})
      2'b11: begin
        q[0] = a_r;     q[1] = a_n;     q[2] = b_n; q[3] = b_r;
      end
      2'b10: begin
        q[0] = a_r;     q[1] = a_n;     q[2] = b_start; q[3] = '0;
      end
      2'b01: begin
        q[0] = a_start; q[1] = b_n;     q[2] = b_r; q[3] = '0;
      end
      default: begin
        q[0] = a_start; q[1] = b_start; q[2] = '0;  q[3] = '0;
      end
    endcase

    if (!ctl.reversed) begin
      v = q;
    end else if (quad) begin
      v[0] = q[3]; v[1] = q[2]; v[2] = q[1]; v[3] = q[0];
    end else begin
      v[0] = q[2]; v[1] = q[1]; v[2] = q[0]; v[3] = '0;
    end

    // Top bit set means the index is past the range
    ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s[i] = v[i][INDEX_BITS] ? '1 : v[i][INDEX_BITS-1:0];
      ovf  = ovf | v[i][INDEX_BITS];
      e[i] = EXT_W'(s[i]);
    end

    face.vertex_count = quad ? rmqi_pkg::VCNT_QUAD : rmqi_pkg::VCNT_TRI;
    face.vertex_a     = e[0][VW-1:0];
    face.vertex_b     = e[1][VW-1:0];
    face.vertex_c     = e[2][VW-1:0];
    face.vertex_d     = e[3][VW-1:0];
    face.overflow     = ovf;
  end

endmodule

`default_nettype wire

>>> rtl/rmqi_seq.sv
`default_nettype none

// Ring state and face sequencer: walks positions and inside/outside copies.
module rmqi_seq #(
  parameter int MAX_REV_MESH = 32,
  parameter int INDEX_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  ring_full,
  input  wire logic                                  starts_mesh,
  input  wire logic [$clog2(MAX_REV_MESH+1)-1:0]     steps,
  input  wire logic [$clog2(MAX_REV_MESH+2)-1:0]     pts_out,
  input  wire logic                                  en_in,
  input  wire logic                                  en_out,
  input  wire logic                                  out_space,
  output logic                                       emit,
  output logic                                       last,
  output logic                                       outside,
  output rmqi_pkg::face_ctl_t                        ctl,
  output logic [$clog2(MAX_REV_MESH)-1:0]            pos,
  output logic [INDEX_BITS:0]                        a_start,
  output logic [INDEX_BITS:0]                        b_start
);

  localparam int IW = INDEX_BITS + 1;
  localparam int RW = $clog2(MAX_REV_MESH);
  localparam int SW = $clog2(MAX_REV_MESH + 1);
  localparam logic [IW-1:0] IDX_LIMIT = IW'(1) << INDEX_BITS;

  rmqi_pkg::seq_state_t state_r, state_nxt;
  logic [RW-1:0] pos_r, pos_nxt;
  logic          phase_r, phase_nxt;
  logic [IW-1:0] a_start_r, a_start_nxt, b_start_r, b_start_nxt;
  logic          a_full_r, a_full_nxt, b_full_r, b_full_nxt;
  logic          have_prev_r, have_prev_nxt;

  logic [IW-1:0] start_sum, start_sat;
  logic          first, any_face, accept;

  assign start_sum = a_start_r + (a_full_r ? IW'(pts_out) : IW'(1));
  assign start_sat = (start_sum > IDX_LIMIT) ? IDX_LIMIT : start_sum;
  assign first     = starts_mesh || !have_prev_r;
  assign any_face  = (a_full_r || ring_full) && (en_in || en_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmqi_pkg::ST_IDLE;
      pos_r       <= '0;
      phase_r     <= 1'b0;
      a_start_r   <= '0;
      a_full_r    <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      a_start_r   <= a_start_nxt;
      a_full_r    <= a_full_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_start_r <= b_start_nxt;
    b_full_r  <= b_full_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    a_start_nxt   = a_start_r;
    a_full_nxt    = a_full_r;
    b_start_nxt   = b_start_r;
    b_full_nxt    = b_full_r;
    have_prev_nxt = have_prev_r;
    in_ready      = 1'b0;
    accept        = 1'b0;
    emit          = 1'b0;
    // phase 1 is the outside copy, which is always the last of a position
    last          = ((SW'(pos_r) + SW'(1)) == steps) && (phase_r || !en_out);

    case (state_r)
      rmqi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept) begin
          if (first) begin
            a_start_nxt   = '0;
            a_full_nxt    = ring_full;
            have_prev_nxt = 1'b1;
          end else if (any_face) begin
            b_start_nxt = start_sat;
            b_full_nxt  = ring_full;
            pos_nxt     = '0;
            phase_nxt   = !en_in;
            state_nxt   = rmqi_pkg::ST_EMIT;
          end else begin
            a_start_nxt = start_sat;
            a_full_nxt  = ring_full;
          end
        end
      end
      rmqi_pkg::ST_EMIT: begin
        emit = out_space;
        if (emit) begin
          if (last) begin
            a_start_nxt = b_start_r;
            a_full_nxt  = b_full_r;
            state_nxt   = rmqi_pkg::ST_IDLE;
          end else if (!phase_r && en_out) begin
            phase_nxt = 1'b1;
          end else begin
            pos_nxt   = pos_r + RW'(1);
            phase_nxt = !en_in;
          end
        end
      end
      default: begin
        state_nxt = rmqi_pkg::ST_IDLE;
      end
    endcase
  end

  assign outside      = phase_r;
  assign ctl.a_full   = a_full_r;
  assign ctl.b_full   = b_full_r;
  assign ctl.reversed = !phase_r;
  assign pos          = pos_r;
  assign a_start      = a_start_r;
  assign b_start      = b_start_r;

endmodule

`default_nettype wire

>>> rtl/rmqi_checker.sv
`default_nettype none

module rmqi_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_starts_mesh,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [rmqi_pkg::VCNT_W-1:0]        out_vertex_count,
  input wire logic [rmqi_pkg::VTX_W-1:0]         out_vertex_a,
  input wire logic [rmqi_pkg::VTX_W-1:0]         out_vertex_d,
  input wire logic                               out_last_face
);

  // Stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_a) &&
      $stable(out_vertex_d) && $stable(out_last_face))
    else $error("stalled result changed");

  // Only triangles and quads
  a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vertex_count == rmqi_pkg::VCNT_TRI) ||
                  (out_vertex_count == rmqi_pkg::VCNT_QUAD))
    else $error("bad vertex count");

  // Triangle carries no fourth vertex
  a_tri_d: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vertex_count == rmqi_pkg::VCNT_TRI) |-> out_vertex_d == '0)
    else $error("triangle with nonzero fourth vertex");

  // No new ring while the current ring still has faces pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_face |-> !in_ready)
    else $error("input taken mid ring");

  // A ring that starts a mesh emits nothing
  a_first_ring: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_starts_mesh && !out_valid |=> !out_valid)
    else $error("face emitted for first ring");

endmodule

bind revolved_mesh_quad_indexer rmqi_checker u_rmqi_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MESH_STEPS_MAX = 32;
  localparam int IDX_BITS = 16;
  localparam longint unsigned IDX_LIMIT = 64'd1 << IDX_BITS;
  localparam longint unsigned IDX_MAX = IDX_LIMIT - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int CW = rmqi_pkg::COLOR_W;
  localparam int NW = rmqi_pkg::VCNT_W;
  localparam int XW = rmqi_pkg::VTX_W;

  typedef struct packed {
    logic full;
    logic starts;
  } ring_t;

  typedef struct packed {
    logic [NW-1:0] vcount;
    logic [XW-1:0] va;
    logic [XW-1:0] vb;
    logic [XW-1:0] vc;
    logic [XW-1:0] vd;
    logic [7:0]    color;
    logic          ovf;
    logic          last;
  } face_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_ring_full = 1'b0;
  logic                               in_starts_mesh = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [NW-1:0]                      out_vertex_count;
  logic [XW-1:0]                      out_vertex_a;
  logic [XW-1:0]                      out_vertex_b;
  logic [XW-1:0]                      out_vertex_c;
  logic [XW-1:0]                      out_vertex_d;
  logic [7:0]                         out_face_color;
  logic                               out_index_overflow;
  logic                               out_last_face;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [rmqi_pkg::CFG_IDX_W-1:0]     cfg_index = rmqi_pkg::CFG_REV_MESH;
  logic [CW-1:0]                      cfg_data = '0;

  // predictor copy of registers and ring state
  logic [rmqi_pkg::REV_MESH_W-1:0] mdl_rev_mesh = rmqi_pkg::REV_MESH_RST;
  logic                  mdl_closed = 1'b0;
  logic [CW-1:0]         mdl_color_in = '1;
  logic [CW-1:0]         mdl_color_out = '1;
  longint unsigned       mdl_prev_start = 0;
  logic                  mdl_prev_full = 1'b0;
  logic                  mdl_have_prev = 1'b0;

  ring_t     ring_backlog[$];
  face_rec_t pending_faces[$];

  int unsigned rings_queued = 0;
  int unsigned rings_sent = 0;
  int unsigned rings_accepted = 0;
  int unsigned cfg_accepted = 0;
  int unsigned faces_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  revolved_mesh_quad_indexer #(
    .MAX_REV_MESH(MESH_STEPS_MAX),
    .INDEX_BITS  (IDX_BITS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_ring_full      (in_ring_full),
    .in_starts_mesh    (in_starts_mesh),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_count  (out_vertex_count),
    .out_vertex_a      (out_vertex_a),
    .out_vertex_b      (out_vertex_b),
    .out_vertex_c      (out_vertex_c),
    .out_vertex_d      (out_vertex_d),
    .out_face_color    (out_face_color),
    .out_index_overflow(out_index_overflow),
    .out_last_face     (out_last_face),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic string face_str(face_rec_t f);
    return $sformatf("n=%0d v=%0d,%0d,%0d,%0d color=%0d ovf=%b last=%b",
                     f.vcount, f.va, f.vb, f.vc, f.vd, f.color, f.ovf, f.last);
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $time, msg);
    end
  endfunction

  function automatic void apply_reg(rmqi_pkg::cfg_reg_e idx, logic [CW-1:0] d);
    case (idx)
      rmqi_pkg::CFG_REV_MESH:      mdl_rev_mesh = d[rmqi_pkg::REV_MESH_W-1:0];
      rmqi_pkg::CFG_CLOSED_REV:    mdl_closed = d[0];
      rmqi_pkg::CFG_COLOR_INSIDE:  mdl_color_in = d;
      rmqi_pkg::CFG_COLOR_OUTSIDE: mdl_color_out = d;
      default: ;
    endcase
  endfunction

  function automatic void push_face(input longint unsigned corner[4], input int unsigned n,
                                    input logic [7:0] color, input logic reversed,
                                    input logic last);
    face_rec_t f;
    logic [XW-1:0] v[4];
    longint unsigned x;
    int unsigned i;
    f = '0;
    v = '{default: '0};
    for (i = 0; i < n; i++) begin
      x = reversed ? corner[n-1-i] : corner[i];
      if (x > IDX_MAX) begin
        x = IDX_MAX;
        f.ovf = 1'b1;
      end
      v[i] = x[XW-1:0];
    end
    f.vcount = NW'(n);
    f.va = v[0];
    f.vb = v[1];
    f.vc = v[2];
    f.vd = v[3];
    f.color = color;
    f.last = last;
    pending_faces.push_back(f);
  endfunction

  // Faces joining the previous ring to this one, inside copy first.
  function automatic void predict_ring_faces(logic full, logic starts);
    int unsigned steps, pts_out, r, nxt, n;
    longint unsigned ring_start;
    longint unsigned corner[4];
    steps = mdl_rev_mesh;
    if (steps < 1) steps = 1;
    if (steps > MESH_STEPS_MAX) steps = MESH_STEPS_MAX;
    pts_out = mdl_closed ? steps : steps + 1;
    if (starts || !mdl_have_prev) begin
      mdl_prev_start = 0;
      mdl_prev_full = full;
      mdl_have_prev = 1'b1;
      return;
    end
    ring_start = mdl_prev_start + (mdl_prev_full ? pts_out : 1);
    if (ring_start > IDX_LIMIT) ring_start = IDX_LIMIT;
    if (mdl_prev_full || full) begin
      for (r = 0; r < steps; r++) begin
        nxt = (r + 1 >= pts_out) ? 0 : r + 1;
        corner = '{default: 0};
        if (mdl_prev_full) begin
          corner[0] = mdl_prev_start + r;
          corner[1] = mdl_prev_start + nxt;
          n = 2;
        end else begin
          corner[0] = mdl_prev_start;
          n = 1;
        end
        if (full) begin
          corner[n] = ring_start + nxt;
          corner[n+1] = ring_start + r;
          n = n + 2;
        end else begin
          corner[n] = ring_start;
          n = n + 1;
        end
        if (!mdl_color_in[CW-1]) begin
          push_face(corner, n, mdl_color_in[7:0], 1'b1,
                    (r == steps - 1) && mdl_color_out[CW-1]);
        end
        if (!mdl_color_out[CW-1]) begin
          push_face(corner, n, mdl_color_out[7:0], 1'b0, r == steps - 1);
        end
      end
    end
    mdl_prev_start = ring_start;
    mdl_prev_full = full;
  endfunction

  function automatic void check_face();
    face_rec_t got, want;
    got = {out_vertex_count, out_vertex_a, out_vertex_b, out_vertex_c, out_vertex_d,
           out_face_color, out_index_overflow, out_last_face};
    faces_checked++;
    if (pending_faces.size() == 0) begin
      note_failure($sformatf("face with nothing pending: %s", face_str(got)));
    end else begin
      want = pending_faces.pop_front();
      if (got !== want) begin
        note_failure($sformatf("face mismatch: expected %s, got %s",
                               face_str(want), face_str(got)));
      end
    end
  endfunction

  // ring driver
  always @(negedge clk) begin : drive_rings
    ring_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && rings_accepted != rings_sent) begin
      // hold until the transaction completes
    end else if (ring_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      rq = ring_backlog.pop_front();
      in_valid <= 1'b1;
      in_ring_full <= rq.full;
      in_starts_mesh <= rq.starts;
      rings_sent <= rings_sent + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin : watch
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(rmqi_pkg::cfg_reg_e'(cfg_index), cfg_data);
        cfg_accepted <= cfg_accepted + 1;
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_ring_faces(in_ring_full, in_starts_mesh);
        rings_accepted <= rings_accepted + 1;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        check_face();
        moved = 1'b1;
      end
      if (moved) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic enqueue_ring(logic full, logic starts);
    ring_t rq;
    rq.full = full;
    rq.starts = starts;
    ring_backlog.push_back(rq);
    rings_queued++;
  endtask

  task automatic wait_drain();
    while (rings_accepted != rings_queued || pending_faces.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(rmqi_pkg::cfg_reg_e idx, logic [CW-1:0] d);
    int unsigned seen;
    @(negedge clk);
    seen = cfg_accepted;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (cfg_accepted == seen);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CW-1:0] rand_color();
    case ($urandom_range(9))
      0:       return '1;
      1:       return {1'b1, 8'($urandom)};
      2:       return '0;
      3:       return {1'b0, 8'hFF};
      default: return {1'b0, 8'($urandom)};
    endcase
  endfunction

  task automatic rand_config();
    logic [CW-1:0] rm;
    case ($urandom_range(7))
      0:       rm = 9'd0;
      1:       rm = 9'd1;
      2:       rm = 9'd32;
      3:       rm = 9'd63;
      default: rm = CW'($urandom_range(2, 12));
    endcase
    rm[8:6] = 3'($urandom);  // ignored bits
    write_reg(rmqi_pkg::CFG_REV_MESH, rm);
    write_reg(rmqi_pkg::CFG_CLOSED_REV, CW'($urandom));
    write_reg(rmqi_pkg::CFG_COLOR_INSIDE, rand_color());
    write_reg(rmqi_pkg::CFG_COLOR_OUTSIDE, rand_color());
  endtask

  // mostly whole meshes (start ring plus followers), some loose rings as noise
  task automatic queue_random_rings(int unsigned count);
    int unsigned made, len, k;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(2, 7);
        for (k = 0; k < len; k++) begin
          enqueue_ring($urandom_range(99) < 75, k == 0);
        end
        made += len;
      end else begin
        enqueue_ring(1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned mode, setting, k;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: colors off, and the first ring has no predecessor
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b1, 1'b0);
    wait_drain();

    write_reg(rmqi_pkg::CFG_REV_MESH, 9'd4);
    write_reg(rmqi_pkg::CFG_CLOSED_REV, 9'd0);
    write_reg(rmqi_pkg::CFG_COLOR_INSIDE, 9'd5);
    write_reg(rmqi_pkg::CFG_COLOR_OUTSIDE, 9'd255);
    enqueue_ring(1'b1, 1'b1);
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b0, 1'b0);
    enqueue_ring(1'b0, 1'b0);  // second collapsed ring in a row: nothing
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b1, 1'b0);
    wait_drain();

    // closed single step, changed in the middle of a mesh
    write_reg(rmqi_pkg::CFG_REV_MESH, 9'd1);
    write_reg(rmqi_pkg::CFG_CLOSED_REV, 9'h1FF);
    write_reg(rmqi_pkg::CFG_COLOR_INSIDE, 9'h1FF);
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b0, 1'b0);
    enqueue_ring(1'b1, 1'b0);
    wait_drain();

    // step count zero behaves as one
    write_reg(rmqi_pkg::CFG_REV_MESH, 9'h0C0);
    write_reg(rmqi_pkg::CFG_CLOSED_REV, 9'd0);
    write_reg(rmqi_pkg::CFG_COLOR_INSIDE, 9'd0);
    write_reg(rmqi_pkg::CFG_COLOR_OUTSIDE, 9'h100);
    enqueue_ring(1'b1, 1'b1);
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b0, 1'b0);
    enqueue_ring(1'b1, 1'b1);
    enqueue_ring(1'b0, 1'b0);
    wait_drain();

    // step count above the maximum clamps
    write_reg(rmqi_pkg::CFG_REV_MESH, 9'd63);
    write_reg(rmqi_pkg::CFG_CLOSED_REV, 9'd1);
    write_reg(rmqi_pkg::CFG_COLOR_INSIDE, 9'd255);
    write_reg(rmqi_pkg::CFG_COLOR_OUTSIDE, 9'd0);
    enqueue_ring(1'b1, 1'b1);
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b0, 1'b0);

    for (mode = 0; mode < 4; mode++) begin
      for (setting = 0; setting < 3; setting++) begin
        wait_drain();
        case (mode)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
        rand_config();
        if (mode == 0 && setting == 0) begin
          // sender holds off until every face has drained
          queue_random_rings(15);
          wait_drain();
          queue_random_rings(15);
        end else begin
          queue_random_rings(26);
        end
      end
    end

    // widest open sweep: every ring after the first gives the most faces
    wait_drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(rmqi_pkg::CFG_REV_MESH, 9'd32);
    write_reg(rmqi_pkg::CFG_CLOSED_REV, 9'd0);
    write_reg(rmqi_pkg::CFG_COLOR_INSIDE, 9'd7);
    write_reg(rmqi_pkg::CFG_COLOR_OUTSIDE, 9'd200);
    enqueue_ring(1'b1, 1'b1);
    for (k = 0; k < 3; k++) enqueue_ring(1'b1, 1'b0);
    enqueue_ring(1'b0, 1'b0);
    enqueue_ring(1'b1, 1'b0);

    wait_drain();
    repeat (20) @(negedge clk);
    if (pending_faces.size() != 0) begin
      note_failure($sformatf("%0d faces never arrived", pending_faces.size()));
    end
    $display("run: %0d rings, %0d faces checked, %0d register writes, %0d mismatches",
             rings_accepted, faces_checked, cfg_accepted, mismatches);
    $display("run: open/closed sweeps, collapsed rings, color disables, widest rings");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/rmqi_pkg.sv
rtl/rmqi_face.sv
rtl/rmqi_seq.sv
rtl/revolved_mesh_quad_indexer.sv
rtl/rmqi_checker.sv
tb/tb_top.sv
